@@ hdl/ste_pkg.sv @@
// package for the sorted table engine: widths, operation codes, cell link types
// used by ste_cell and sorted_table_engine_core
`timescale 1ns / 1ps
package ste_pkg;
    localparam int KEY_W = 32;
    localparam int CNT_W = 11;
    localparam int POS_W = 11;
    localparam int KIND_W = 3;
    localparam int DEPTH_DEF = 1024;

    localparam logic [KIND_W-1:0] K_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] K_RM_FIRST = 3'd1;
    localparam logic [KIND_W-1:0] K_RM_POS = 3'd2;
    localparam logic [KIND_W-1:0] K_RM_LAST = 3'd3;
    localparam logic [KIND_W-1:0] K_FIND_SK = 3'd4;
    localparam logic [KIND_W-1:0] K_FIND_ID = 3'd5;

    // one stored entry
    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] sk;
        logic [KEY_W-1:0] id;
    } t_entry;

    // broadcast command to every cell
    typedef struct packed {
        logic             ins;   // insert: cells at or past the slot shift up
        logic             rm;    // remove: cells at or past the slot shift down
        logic [KEY_W-1:0] sk;
        logic [KEY_W-1:0] id;
    } t_cmd;
endpackage

@@ hdl/sorted_table_engine_core.sv @@
// top level of the sorted table engine: a row of cells plus the sequencer
// depends on ste_pkg and ste_cell
//
// channel  dir  handshake              fields
// command  in   i_start & !o_busy      i_kind i_sort_key i_id_key i_position
// result   out  o_done, one cycle      o_ok o_count o_entry_sort_key o_entry_id
//
// each item has a compare cycle over all cells (match vectors registered),
// then a shift/report cycle; o_busy is high during the second.
// the result strobe o_done comes the cycle after, overlapping the next compare.
// reset clears the count and every cell's valid bit.
// the receiver cannot stall; results are never held.
`timescale 1ns / 1ps
module sorted_table_engine_core #(
    parameter int DEPTH = ste_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [ste_pkg::KIND_W-1:0]   i_kind,
    input  logic [ste_pkg::KEY_W-1:0]    i_sort_key,
    input  logic [ste_pkg::KEY_W-1:0]    i_id_key,
    input  logic [ste_pkg::POS_W-1:0]    i_position,
    output logic                         o_done,
    output logic                         o_ok,
    output logic [ste_pkg::CNT_W-1:0]    o_count,
    output logic [ste_pkg::KEY_W-1:0]    o_entry_sort_key,
    output logic [ste_pkg::KEY_W-1:0]    o_entry_id
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    typedef enum logic {S_CMP, S_EXEC} t_state;
    t_state r_state;

    logic [ste_pkg::KIND_W-1:0] r_kind;
    logic [ste_pkg::KEY_W-1:0]  r_sk, r_id;
    logic [ste_pkg::POS_W-1:0]  r_pos;
    logic [CW-1:0]              r_cnt;
    logic [DEPTH-1:0]           r_gt, r_skeq, r_ideq;

    ste_pkg::t_cmd   w_cmd;
    ste_pkg::t_entry w_e [DEPTH];
    logic [DEPTH-1:0] w_gt, w_skeq, w_ideq, w_sel, w_slot;
    logic [DEPTH-1:0] w_onehot_sk, w_onehot_id;
    logic [DEPTH-1:0] w_rmsel, w_rmslot;
    logic [IW-1:0]    w_rmidx;
    logic             w_rmok, w_exec;
    logic             w_ins_ok;

    assign w_exec = (r_state == S_EXEC);
    assign o_busy = w_exec;

    // command to the cells: input key during compare, registered key during exec
    assign w_cmd.sk  = r_state == S_CMP ? i_sort_key : r_sk;
    assign w_cmd.id  = r_state == S_CMP ? i_id_key : r_id;
    assign w_ins_ok  = r_cnt < CW'(DEPTH);
    assign w_cmd.ins = w_exec && r_kind == ste_pkg::K_INSERT && w_ins_ok;
    assign w_cmd.rm  = w_exec && w_rmok;

    // remove index from kind
    always_comb begin
        w_rmok  = 1'b0;
        w_rmidx = '0;
        case (r_kind)
            ste_pkg::K_RM_FIRST: begin
                w_rmok = r_cnt != '0;
            end
            ste_pkg::K_RM_POS: begin
                w_rmok  = r_pos != '0 && 32'(r_pos) <= 32'(r_cnt);
                w_rmidx = IW'(r_pos - 1'b1);
            end
            ste_pkg::K_RM_LAST: begin
                w_rmok  = r_cnt != '0;
                w_rmidx = IW'(r_cnt - 1'b1);
            end
            default: begin
                w_rmok = 1'b0;
            end
        endcase
    end

    // selection masks: insert slot is first cell greater (or first empty)
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_sel[i]    = r_gt[i] || !w_e[i].vld;
            w_rmsel[i]  = i >= int'(w_rmidx);
            w_rmslot[i] = i == int'(w_rmidx);
        end
        w_slot = w_sel & ~(w_sel << 1);
        w_onehot_sk = r_skeq & ~(r_skeq - 1'b1);
        w_onehot_id = r_ideq & ~(r_ideq - 1'b1);
    end

    // cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ste_pkg::t_entry w_lo, w_up;
        assign w_lo = (g == 0) ? ste_pkg::t_entry'('0) : w_e[(g == 0) ? 0 : g-1];
        assign w_up = (g == DEPTH-1) ? ste_pkg::t_entry'('0) : w_e[(g == DEPTH-1) ? g : g+1];
        ste_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_sel   (w_cmd.rm ? w_rmsel[g] : w_sel[g]),
            .i_slot  (w_slot[g]),
            .i_lower (w_lo),
            .i_upper (w_up),
            .o_entry (w_e[g]),
            .o_gt    (w_gt[g]),
            .o_sk_eq (w_skeq[g]),
            .o_id_eq (w_ideq[g])
        );
    end

    // pick the reported entry: or-reduce of a one-hot mask
    logic [ste_pkg::KEY_W-1:0] w_rs, w_ri;
    logic [DEPTH-1:0]          w_pick;
    always_comb begin
        case (r_kind)
            ste_pkg::K_FIND_SK: w_pick = w_onehot_sk;
            ste_pkg::K_FIND_ID: w_pick = w_onehot_id;
            default:            w_pick = w_rmok ? w_rmslot : '0;
        endcase
        w_rs = '0;
        w_ri = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rs |= w_pick[i] ? w_e[i].sk : '0;
            w_ri |= w_pick[i] ? w_e[i].id : '0;
        end
    end

    // sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CMP;
            r_cnt   <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_CMP: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_CMP;
                    o_done  <= 1'b1;
                    if (w_cmd.ins) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (w_cmd.rm) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: r_state <= S_CMP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP && i_start) begin
            r_kind <= i_kind;
            r_sk   <= i_sort_key;
            r_id   <= i_id_key;
            r_pos  <= i_position;
            r_gt   <= w_gt;
            r_skeq <= w_skeq;
            r_ideq <= w_ideq;
        end
        if (w_exec) begin
            o_ok <= w_cmd.ins || w_cmd.rm || (w_pick != '0 &&
                    (r_kind == ste_pkg::K_FIND_SK || r_kind == ste_pkg::K_FIND_ID));
            o_count <= ste_pkg::CNT_W'(w_cmd.ins ? r_cnt + 1'b1 :
                                       w_cmd.rm ? r_cnt - 1'b1 : r_cnt);
            o_entry_sort_key <= w_rs;
            o_entry_id       <= w_ri;
        end
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("count above depth");
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> o_done) else $error("missing result strobe");
    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.ins && w_cmd.rm)) else $error("insert and remove together");
    a_slot_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |-> $onehot(w_slot)) else $error("insert slot not unique");
`endif
endmodule

@@ hdl/ste_cell.sv @@
// one cell of the sorted table: holds an entry, shifts with its neighbors
// depends on ste_pkg
`timescale 1ns / 1ps
module ste_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ste_pkg::t_cmd    i_cmd,
    input  logic             i_sel,      // this cell is at or past the slot
    input  logic             i_slot,     // this cell is the slot itself
    input  ste_pkg::t_entry  i_lower,    // neighbor below
    input  ste_pkg::t_entry  i_upper,    // neighbor above
    output ste_pkg::t_entry  o_entry,
    output logic             o_gt,       // stored key above the command key
    output logic             o_sk_eq,
    output logic             o_id_eq
);
    ste_pkg::t_entry r_e;
    ste_pkg::t_entry n_e;

    // next entry from the shift direction
    always_comb begin
        n_e = r_e;
        if (i_cmd.ins && i_sel) begin
            n_e = i_slot ? ste_pkg::t_entry'{vld: 1'b1, sk: i_cmd.sk, id: i_cmd.id} : i_lower;
        end else if (i_cmd.rm && i_sel) begin
            n_e = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.vld <= 1'b0;
        end else begin
            r_e.vld <= n_e.vld;
        end
        r_e.sk <= n_e.sk;
        r_e.id <= n_e.id;
    end

    // compares against the command key
    assign o_gt    = r_e.vld && (r_e.sk > i_cmd.sk);
    assign o_sk_eq = r_e.vld && (r_e.sk == i_cmd.sk);
    assign o_id_eq = r_e.vld && (r_e.id == i_cmd.id);
    assign o_entry = r_e;
endmodule
